>>> rtl/blgs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blgs_pkg: shared types and constants
// Command and proposal codes, the queued item record and the sequencer
// states of the bipartite link Gibbs step.
// ----------------------------------------------------------------------------
package blgs_pkg;

	typedef enum logic [1:0] {
		CMD_PROPOSE = 2'd0,
		CMD_PRELOAD = 2'd1,
		CMD_LOAD    = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_REMOVE = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LOGS,
		ST_MUL_T,
		ST_RND_T,
		ST_MUL_A,
		ST_RND_A,
		ST_APPLY,
		ST_OUT
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [9:0]         row_index;
		logic [9:0]         col_index;
		logic signed [47:0] lla;
		logic signed [47:0] llb;
		logic signed [47:0] lll;
		logic [15:0]        gamma_value;
		logic [15:0]        random_draw;
		logic signed [47:0] load_value;
		logic               ok;
	} item_t;

	localparam logic signed [47:0] LIMIT_Q16 = 48'sd655360000000;
	localparam logic [29:0]        LN2_Q30   = 30'd744261118;
	localparam logic [51:0]        ROUND_Q30 = 52'd536870912;
	localparam logic signed [47:0] LL_MAX    = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] LL_MIN    = -48'sh8000_0000_0000;
	localparam logic [16:0]        ONE_Q16   = 17'd65536;
	localparam logic [2:0]         LOG_LAST  = 3'd4;

endpackage
`default_nettype wire

>>> rtl/blgs_log2.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blgs_log2: iterative base-two logarithm
// Normalises the operand to Q1.30 and produces one fraction bit per cycle
// by squaring, giving the logarithm in Q16 after sixteen iterations.
// ----------------------------------------------------------------------------
module blgs_log2
	import blgs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [16:0] x,
	output logic             busy,
	output logic             done,
	output logic [20:0]      result
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  bit_q;
	logic [30:0] m_q;
	logic [4:0]  e_q;
	logic [15:0] f_q;
	logic [4:0]  e_d;
	logic [61:0] sq;
	logic [31:0] sq_hi;

	always_comb begin
		e_d = 5'd0;
		for (int i = 0; i < 17; i++) begin
			if (x[i]) begin
				e_d = 5'(i);
			end
		end
		sq    = 62'(m_q) * 62'(m_q);
		sq_hi = sq[61:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				bit_q  <= 4'd15;
			end else if (busy_q) begin
				bit_q <= bit_q - 4'd1;
				if (bit_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			e_q <= e_d;
			m_q <= 31'(x) << (5'd30 - e_d);
			f_q <= 16'd0;
		end else if (busy_q) begin
			if (sq_hi[31]) begin
				f_q[bit_q] <= 1'b1;
				m_q        <= sq_hi[31:1];
			end else begin
				m_q <= sq_hi[30:0];
			end
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = {e_q, f_q};

endmodule
`default_nettype wire

>>> rtl/blgs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blgs_front: input queue and classification
// Accepts items, checks the indices against the table sizes, replaces a
// zero prior by one and holds up to two items for the back end.
// ----------------------------------------------------------------------------
module blgs_front
	import blgs_pkg::*;
#(
	parameter int ROWS_A = 1024,
	parameter int COLS_B = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         cmd,
	input  wire logic [9:0]         row_index,
	input  wire logic [9:0]         col_index,
	input  wire logic signed [47:0] lla,
	input  wire logic signed [47:0] llb,
	input  wire logic signed [47:0] lll,
	input  wire logic [15:0]        gamma_value,
	input  wire logic [15:0]        random_draw,
	input  wire logic signed [47:0] load_value,
	input  wire logic               clearing,
	output logic                    head_valid,
	output item_t                   head,
	input  wire logic               take
);

	localparam logic [16:0] ROW_LIM = 17'(ROWS_A);
	localparam logic [16:0] COL_LIM = 17'(COLS_B);

	item_t      entry_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	item_t      item_d;
	logic       wr;
	logic       rd;

	always_comb begin
		item_d.cmd         = cmd_t'(cmd);
		item_d.row_index   = row_index;
		item_d.col_index   = col_index;
		item_d.lla         = lla;
		item_d.llb         = llb;
		item_d.lll         = lll;
		item_d.gamma_value = (gamma_value == 16'd0) ? 16'd1 : gamma_value;
		item_d.random_draw = random_draw;
		item_d.load_value  = load_value;
		item_d.ok          = (17'(row_index) < ROW_LIM) && (17'(col_index) < COL_LIM);
	end

	assign full       = (cnt_q == 2'd2) || clearing;
	assign wr         = push && !full;
	assign head_valid = (cnt_q != 2'd0);
	assign rd         = take && head_valid;
	assign head       = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr) begin
				wptr_q <= !wptr_q;
			end
			if (rd) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wptr_q] <= item_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/blgs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// blgs_back: link table sequencer
// Reads the link tables, forms the proposal, evaluates the logarithm terms
// on a shared unit, decides acceptance and writes the tables back.
// ----------------------------------------------------------------------------
module blgs_back
	import blgs_pkg::*;
#(
	parameter int ROWS_A = 1024,
	parameter int COLS_B = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [10:0]        count_b,
	output logic                    clearing,
	input  wire logic               head_valid,
	input  wire item_t              head,
	output logic                    take,
	output logic                    empty,
	input  wire logic               pop,
	output logic                    linked,
	output logic                    changed,
	output logic [1:0]              proposal_kind,
	output logic signed [47:0]      loglik_now,
	output logic [10:0]             link_total
);

	localparam int RDEPTH    = (ROWS_A < 1024) ? ROWS_A : 1024;
	localparam int CDEPTH    = (COLS_B < 1024) ? COLS_B : 1024;
	localparam int RA_W      = $clog2(RDEPTH);
	localparam int CA_W      = $clog2(CDEPTH);
	localparam int CLR_DEPTH = (RDEPTH > CDEPTH) ? RDEPTH : CDEPTH;
	localparam int CL_W      = $clog2(CLR_DEPTH);

	logic [10:0] row_mem [RDEPTH];
	logic        col_mem [CDEPTH];

	state_t             state_q, state_d;
	logic [CL_W-1:0]    clr_q;
	logic signed [47:0] loglik_q;
	logic [10:0]        link_q;
	logic [2:0]         idx_q;
	logic               out_valid_q;

	item_t              item_q;
	logic [10:0]        rrow_q;
	logic               ccol_q;
	kind_t              kind_q;
	logic [16:0]        n_q;
	logic signed [22:0] tsum_q;
	logic signed [22:0] asum_q;
	logic [51:0]        prod_q;
	logic               sneg_q;
	logic signed [22:0] st_q;
	logic signed [22:0] sa_q;
	logic               res_linked_q;
	logic               res_changed_q;
	logic               out_linked_q;
	logic               out_changed_q;
	kind_t              out_kind_q;
	logic signed [47:0] out_loglik_q;
	logic [10:0]        out_link_q;

	logic               row_we, col_we, col_wdata, out_load, log_start;
	logic [RA_W-1:0]    row_waddr;
	logic [CA_W-1:0]    col_waddr;
	logic [10:0]        row_wdata;
	logic [2:0]         log_sel;
	logic [16:0]        log_x;
	logic               log_busy, log_done;
	logic [20:0]        log_res;
	logic signed [22:0] log_ext;
	logic               pair, free, is_prop, add_c, rem_c, pre_c, clr_last, accept;
	logic signed [12:0] diff;
	logic [16:0]        n_sel;
	logic signed [49:0] base;
	logic signed [50:0] dsum, delta;
	logic signed [51:0] llsum;
	logic signed [47:0] llsat;
	logic signed [22:0] src;
	logic               src_neg;
	logic [21:0]        mag;
	logic [21:0]        rnd;
	logic signed [22:0] scaled;

	blgs_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      (log_x),
		.busy   (log_busy),
		.done   (log_done),
		.result (log_res)
	);

	always_comb begin
		pair     = rrow_q[10] && (rrow_q[9:0] == item_q.col_index);
		free     = !rrow_q[10] && !ccol_q;
		is_prop  = item_q.ok && (item_q.cmd == CMD_PROPOSE);
		add_c    = is_prop && free && (item_q.lll < LIMIT_Q16);
		rem_c    = is_prop && !add_c && pair;
		pre_c    = item_q.ok && (item_q.cmd == CMD_PRELOAD) && free;
		diff     = $signed(13'(count_b)) - $signed(13'(link_q)) + (add_c ? 13'sd0 : 13'sd1);
		n_sel    = (diff < 13'sd1) ? 17'd1 : 17'(diff);
		base     = 50'(item_q.lll) - 50'(item_q.lla) - 50'(item_q.llb);
		dsum     = 51'(base) + 51'(st_q);
		delta    = (kind_q == KIND_ADD) ? dsum : -dsum;
		accept   = (item_q.random_draw == 16'd0) || (delta > 51'(sa_q));
		llsum    = 52'(loglik_q) + 52'(delta);
		if (llsum > 52'(LL_MAX)) begin
			llsat = LL_MAX;
		end else if (llsum < 52'(LL_MIN)) begin
			llsat = LL_MIN;
		end else begin
			llsat = llsum[47:0];
		end
		log_ext  = $signed({2'b00, log_res});
		src      = (state_q == ST_MUL_T) ? tsum_q : asum_q;
		src_neg  = src[22];
		mag      = src_neg ? 22'(-src) : 22'(src);
		rnd      = 22'((prod_q + ROUND_Q30) >> 30);
		scaled   = sneg_q ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
		clr_last = (clr_q == CL_W'(CLR_DEPTH - 1));
	end

	always_comb begin
		case (log_sel)
			3'd0:    log_x = {1'b0, item_q.gamma_value};
			3'd1:    log_x = ONE_Q16 - {1'b0, item_q.gamma_value};
			3'd2:    log_x = n_q;
			3'd3:    log_x = {1'b0, item_q.random_draw};
			default: log_x = ONE_Q16 - {1'b0, item_q.random_draw};
		endcase
	end

	always_comb begin
		state_d   = state_q;
		take      = 1'b0;
		log_start = 1'b0;
		log_sel   = idx_q + 3'd1;
		row_we    = 1'b0;
		row_waddr = item_q.row_index[RA_W-1:0];
		row_wdata = 11'd0;
		col_we    = 1'b0;
		col_waddr = item_q.col_index[CA_W-1:0];
		col_wdata = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				row_we    = ({1'b0, clr_q} < (CL_W + 1)'(RDEPTH));
				row_waddr = clr_q[RA_W-1:0];
				col_we    = ({1'b0, clr_q} < (CL_W + 1)'(CDEPTH));
				col_waddr = clr_q[CA_W-1:0];
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (head_valid) begin
					take    = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (add_c || rem_c) begin
					log_start = 1'b1;
					log_sel   = 3'd0;
					state_d   = ST_LOGS;
				end else begin
					if (pre_c) begin
						row_we    = 1'b1;
						row_wdata = {1'b1, item_q.col_index};
						col_we    = 1'b1;
						col_wdata = 1'b1;
					end
					state_d = ST_OUT;
				end
			end
			ST_LOGS: begin
				if (log_done) begin
					if (idx_q == LOG_LAST) begin
						state_d = ST_MUL_T;
					end else begin
						log_start = 1'b1;
					end
				end
			end
			ST_MUL_T: state_d = ST_RND_T;
			ST_RND_T: state_d = ST_MUL_A;
			ST_MUL_A: state_d = ST_RND_A;
			ST_RND_A: state_d = ST_APPLY;
			ST_APPLY: begin
				if (accept) begin
					row_we    = 1'b1;
					row_wdata = (kind_q == KIND_ADD) ? {1'b1, item_q.col_index} : 11'd0;
					col_we    = 1'b1;
					col_wdata = (kind_q == KIND_ADD);
				end
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		rrow_q <= row_mem[head.row_index[RA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[col_waddr] <= col_wdata;
		end
		ccol_q <= col_mem[head.col_index[CA_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			loglik_q    <= '0;
			link_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CL_W'(1);
			end
			if (state_q == ST_READ) begin
				idx_q <= 3'd0;
				if (pre_c) begin
					link_q <= link_q + 11'd1;
				end
				if (item_q.cmd == CMD_LOAD) begin
					loglik_q <= item_q.load_value;
				end
			end
			if (state_q == ST_LOGS && log_done) begin
				idx_q <= idx_q + 3'd1;
			end
			if (state_q == ST_APPLY && accept) begin
				loglik_q <= llsat;
				if (kind_q == KIND_ADD) begin
					link_q <= link_q + 11'd1;
				end else if (link_q != 11'd0) begin
					link_q <= link_q - 11'd1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= head;
		end
		case (state_q)
			ST_READ: begin
				kind_q        <= add_c ? KIND_ADD : (rem_c ? KIND_REMOVE : KIND_NONE);
				n_q           <= n_sel;
				res_changed_q <= pre_c;
				res_linked_q  <= pre_c || (item_q.ok && pair);
			end
			ST_LOGS: begin
				if (log_done) begin
					case (idx_q)
						3'd0:    tsum_q <= log_ext;
						3'd1:    tsum_q <= tsum_q - log_ext;
						3'd2:    tsum_q <= tsum_q - log_ext;
						3'd3:    asum_q <= log_ext;
						default: asum_q <= asum_q - log_ext;
					endcase
				end
			end
			ST_MUL_T, ST_MUL_A: begin
				prod_q <= mag * LN2_Q30;
				sneg_q <= src_neg;
			end
			ST_RND_T: st_q <= scaled;
			ST_RND_A: sa_q <= scaled;
			ST_APPLY: begin
				res_changed_q <= accept;
				res_linked_q  <= (kind_q == KIND_ADD) ? accept : !accept;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_linked_q  <= res_linked_q;
			out_changed_q <= res_changed_q;
			out_kind_q    <= kind_q;
			out_loglik_q  <= loglik_q;
			out_link_q    <= link_q;
		end
	end

	assign clearing      = (state_q == ST_CLEAR);
	assign empty         = !out_valid_q;
	assign linked        = out_linked_q;
	assign changed       = out_changed_q;
	assign proposal_kind = out_kind_q;
	assign loglik_now    = out_loglik_q;
	assign link_total    = out_link_q;

`ifndef NO_ASSERTIONS
	a_log_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		log_start |-> !log_busy)
		else $error("Logarithm unit started while busy.");

	a_link_update: assert property (@(posedge clk) disable iff (!arst_n)
		(link_q != $past(link_q)) |-> ($past(state_q) == ST_READ || $past(state_q) == ST_APPLY))
		else $error("Link count changed outside an update step.");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || pop))
		else $error("Result register overwritten before it was taken.");
`endif

endmodule
`default_nettype wire

>>> rtl/bipartite_link_gibbs_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bipartite_link_gibbs_step: one-to-one record link Gibbs update
// A proposal that is made takes five logarithm evaluations on one shared
// unit; any other item skips them. One item is worked on at a time, and the
// next is not started until the result of the last has been loaded into the
// output register; two more can queue.
// Reset: after arst_n is released a clearing pass empties the link tables,
// with full held high until it is done.
// ----------------------------------------------------------------------------
module bipartite_link_gibbs_step
	import blgs_pkg::*;
#(
	parameter int ROWS_A = 1024,
	parameter int COLS_B = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [10:0]        cfg_wdata,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         cmd,
	input  wire logic [9:0]         row_index,
	input  wire logic [9:0]         col_index,
	input  wire logic signed [47:0] lla,
	input  wire logic signed [47:0] llb,
	input  wire logic signed [47:0] lll,
	input  wire logic [15:0]        gamma_value,
	input  wire logic [15:0]        random_draw,
	input  wire logic signed [47:0] load_value,
	output logic                    empty,
	input  wire logic               pop,
	output logic                    linked,
	output logic                    changed,
	output logic [1:0]              proposal_kind,
	output logic signed [47:0]      loglik_now,
	output logic [10:0]             link_total
);

	logic [10:0] count_b_q;
	logic        clearing;
	logic        head_valid;
	item_t       head;
	logic        take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_b_q <= 11'd1024;
		end else if (cfg_we) begin
			count_b_q <= cfg_wdata;
		end
	end

	blgs_front #(
		.ROWS_A (ROWS_A),
		.COLS_B (COLS_B)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.row_index   (row_index),
		.col_index   (col_index),
		.lla         (lla),
		.llb         (llb),
		.lll         (lll),
		.gamma_value (gamma_value),
		.random_draw (random_draw),
		.load_value  (load_value),
		.clearing    (clearing),
		.head_valid  (head_valid),
		.head        (head),
		.take        (take)
	);

	blgs_back #(
		.ROWS_A (ROWS_A),
		.COLS_B (COLS_B)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.count_b       (count_b_q),
		.clearing      (clearing),
		.head_valid    (head_valid),
		.head          (head),
		.take          (take),
		.empty         (empty),
		.pop           (pop),
		.linked        (linked),
		.changed       (changed),
		.proposal_kind (proposal_kind),
		.loglik_now    (loglik_now),
		.link_total    (link_total)
	);

endmodule
`default_nettype wire
